// File: hdl/lsps_pkg.sv
// Shared types and constants for the leftmost-sparsest pivot search block.
package lsps_pkg;

    // Fixed field widths of the streaming interface
    localparam int ColBits    = 12;
    localparam int RowBits    = 16;
    localparam int WeightBits = 13;
    localparam int NumColBits = 13;
    localparam int CountBits  = 13;

    // Weight saturation value and the reset value of the running minimum
    localparam logic [WeightBits-1:0] WeightMax = '1;
    localparam logic [ColBits-1:0]    MinReset  = '1;
    localparam logic [NumColBits-1:0] NumColReset = 13'd4096;

    // Summary of one finished row, handed from the accumulator to the table stage
    typedef struct packed {
        logic [RowBits-1:0]    row;
        logic [ColBits-1:0]    min_col;
        logic [WeightBits-1:0] weight;
        logic                  was_empty;
        logic                  err;
    } t_row_end;

    // One result transaction
    typedef struct packed {
        logic [RowBits-1:0]   done_row;
        logic [ColBits-1:0]   pivot_column;
        logic                 row_was_empty;
        logic                 accepted;
        logic                 displaced_valid;
        logic [RowBits-1:0]   displaced_row;
        logic [CountBits-1:0] pivot_total;
        logic                 column_error;
    } t_result;

endpackage

// File: hdl/leftmost_sparsest_pivot_search.sv
// Top level of the leftmost-sparsest pivot search block.
//
// Usage: sparse matrix entries stream in on the s_axis channel, one nonzero per
// transaction, row by row. tlast marks the last entry of a row; tuser marks an
// empty row (the column is ignored and the row ends). For every finished row one
// result transaction leaves on m_axis; entries inside a row give none.
// The cfg channel writes num_columns (always ready); write it only while idle.
// Throughput: one entry per cycle while s_axis tready is high. The row-end table
// read is registered and the owner update is written the next cycle, forwarded
// to a following row end, so rows may end on consecutive cycles. A row end's
// result is registered in the table stage, then in the buffer that feeds m_axis.
// Reset: the owner table is swept to empty, one column per cycle, over all
// min(MAX_COLUMNS, 4096) entries; s_axis tready stays low during that sweep.
// Stall: a two-entry result buffer absorbs back-pressure; s_axis tready drops
// once results in flight would overflow it, and no result is ever lost.
module leftmost_sparsest_pivot_search #(
    parameter int MAX_COLUMNS    = 4096,
    parameter int ROW_INDEX_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input entry channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // row_index[15:0], column[27:16], zero fill
    input  logic        i_s_axis_tuser,   // empty_row
    input  logic        i_s_axis_tlast,   // last_in_row
    // Result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // done_row[15:0], pivot_column[27:16], accepted[28], displaced_valid[29],
    // displaced_row[45:30], pivot_total[58:46], column_error[59], zero fill
    output logic [63:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // row_was_empty
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data        // num_columns
);

    logic [lsps_pkg::NumColBits-1:0] r_num_columns;
    logic                            w_in_hs;
    logic                            w_end_valid;
    lsps_pkg::t_row_end              w_end;
    logic                            w_busy;
    logic                            w_res_valid;
    lsps_pkg::t_result               w_res;
    lsps_pkg::t_result               w_out;
    logic [1:0]                      w_count;
    logic [1:0]                      w_occ;

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_columns <= lsps_pkg::NumColReset;
        end else if (i_cfg_valid) begin
            r_num_columns <= i_cfg_data;
        end
    end

    // Accept only when every result in flight has a buffer slot
    always_comb begin
        w_occ           = w_count + 2'(w_res_valid)
                          - 2'(o_m_axis_tvalid && i_m_axis_tready);
        o_s_axis_tready = !w_busy && (w_occ <= 2'd1);
        w_in_hs         = i_s_axis_tvalid && o_s_axis_tready;
    end

    lsps_row_acc #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .ROW_INDEX_BITS(ROW_INDEX_BITS)
    ) u_row_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_in_hs),
        .i_row        (i_s_axis_tdata[15:0]),
        .i_col        (i_s_axis_tdata[27:16]),
        .i_empty      (i_s_axis_tuser),
        .i_last       (i_s_axis_tlast),
        .i_num_columns(r_num_columns),
        .o_end_valid  (w_end_valid),
        .o_end        (w_end)
    );

    lsps_pivot_table #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .ROW_INDEX_BITS(ROW_INDEX_BITS)
    ) u_pivot_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_end_valid(w_end_valid),
        .i_end      (w_end),
        .o_busy     (w_busy),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    lsps_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_valid),
        .i_data (w_res),
        .i_ready(i_m_axis_tready),
        .o_valid(o_m_axis_tvalid),
        .o_data (w_out),
        .o_count(w_count)
    );

    // Result packing
    assign o_m_axis_tdata = {4'b0, w_out.column_error, w_out.pivot_total,
                             w_out.displaced_row, w_out.displaced_valid,
                             w_out.accepted, w_out.pivot_column, w_out.done_row};
    assign o_m_axis_tuser = w_out.row_was_empty;

endmodule

// File: hdl/lsps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lsps_row_acc.sv
// Per-row accumulator: leftmost valid column, entry count and range error.
module lsps_row_acc #(
    parameter int MAX_COLUMNS    = 4096,
    parameter int ROW_INDEX_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [lsps_pkg::RowBits-1:0]    i_row,
    input  logic [lsps_pkg::ColBits-1:0]    i_col,
    input  logic                            i_empty,
    input  logic                            i_last,
    input  logic [lsps_pkg::NumColBits-1:0] i_num_columns,
    output logic                            o_end_valid,
    output lsps_pkg::t_row_end              o_end
);

    localparam int RW = (ROW_INDEX_BITS < lsps_pkg::RowBits) ? ROW_INDEX_BITS
                                                              : lsps_pkg::RowBits;

    logic [lsps_pkg::ColBits-1:0]    r_min;
    logic [lsps_pkg::WeightBits-1:0] r_weight;
    logic                            r_err;
    logic [lsps_pkg::ColBits-1:0]    n_min;
    logic [lsps_pkg::WeightBits-1:0] n_weight;
    logic                            n_err;
    logic                            w_col_ok;
    logic                            w_end;

    // Fold the current entry into the running row state
    always_comb begin
        w_col_ok = !i_empty
                   && (lsps_pkg::NumColBits'(i_col) < i_num_columns)
                   && (32'(i_col) < MAX_COLUMNS);
        n_min    = (w_col_ok && (r_weight == '0 || i_col < r_min)) ? i_col : r_min;
        n_weight = (w_col_ok && r_weight != lsps_pkg::WeightMax)
                   ? r_weight + lsps_pkg::WeightBits'(1) : r_weight;
        n_err    = r_err | (!i_empty && !w_col_ok);
        w_end    = i_empty || i_last;
    end

    // Row summary, valid with the transaction that ends the row
    always_comb begin
        o_end_valid     = i_valid && w_end;
        o_end.row       = lsps_pkg::RowBits'(i_row[RW-1:0]);
        o_end.min_col   = n_min;
        o_end.weight    = n_weight;
        o_end.was_empty = i_empty || (n_weight == '0);
        o_end.err       = n_err;
    end

    // Running state, cleared at each row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= lsps_pkg::MinReset;
            r_weight <= '0;
            r_err    <= 1'b0;
        end else if (i_valid) begin
            if (w_end) begin
                r_min    <= lsps_pkg::MinReset;
                r_weight <= '0;
                r_err    <= 1'b0;
            end else begin
                r_min    <= n_min;
                r_weight <= n_weight;
                r_err    <= n_err;
            end
        end
    end

endmodule

// File: hdl/lsps_pivot_table.sv
// Column owner table: clearing pass, read-modify-write with forwarding, result build.
module lsps_pivot_table #(
    parameter int MAX_COLUMNS    = 4096,
    parameter int ROW_INDEX_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_end_valid,
    input  lsps_pkg::t_row_end i_end,
    output logic               o_busy,
    output logic               o_res_valid,
    output lsps_pkg::t_result  o_res
);

    localparam int DEPTH = (MAX_COLUMNS < 4096) ? MAX_COLUMNS : 4096;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = (ROW_INDEX_BITS < lsps_pkg::RowBits) ? ROW_INDEX_BITS
                                                                 : lsps_pkg::RowBits;
    localparam int WB    = lsps_pkg::WeightBits;
    localparam int EW    = 1 + RW + WB;

    logic                              r_clear;
    logic [AW-1:0]                     r_clr_addr;
    logic                              r_s2_valid;
    lsps_pkg::t_row_end                r_s2;
    logic                              r_fwd_en;
    logic [AW-1:0]                     r_fwd_addr;
    logic [EW-1:0]                     r_fwd_data;
    logic [lsps_pkg::CountBits-1:0]    r_count;
    logic [lsps_pkg::CountBits-1:0]    n_count;

    logic                              w_we;
    logic [AW-1:0]                     w_waddr;
    logic [EW-1:0]                     w_wdata;
    logic [EW-1:0]                     w_rdata;
    logic [EW-1:0]                     w_entry;
    logic [AW-1:0]                     w_s2_addr;
    logic                              w_own_valid;
    logic [RW-1:0]                     w_own_row;
    logic [WB-1:0]                     w_own_weight;
    logic                              w_acc;
    logic                              w_new;

    lsps_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (i_end_valid),
        .i_raddr(i_end.min_col[AW-1:0]),
        .o_rdata(w_rdata)
    );

    // Owner entry seen by stage two, with the last cycle's write forwarded
    always_comb begin
        w_s2_addr    = r_s2.min_col[AW-1:0];
        w_entry      = (r_fwd_en && r_fwd_addr == w_s2_addr) ? r_fwd_data : w_rdata;
        w_own_valid  = w_entry[EW-1];
        w_own_row    = w_entry[EW-2 -: RW];
        w_own_weight = w_entry[WB-1:0];
        w_acc        = r_s2_valid && !r_s2.was_empty
                       && (!w_own_valid || r_s2.weight < w_own_weight);
        w_new        = w_acc && !w_own_valid;
        n_count      = r_count + lsps_pkg::CountBits'(w_new);
    end

    // Table write: clearing sweep or new owner
    always_comb begin
        w_we    = r_clear || w_acc;
        w_waddr = r_clear ? r_clr_addr : w_s2_addr;
        w_wdata = r_clear ? '0 : {1'b1, r_s2.row[RW-1:0], r_s2.weight};
    end

    // Result of the finished row
    always_comb begin
        o_res.done_row        = r_s2.row;
        o_res.pivot_column    = r_s2.was_empty ? '0 : r_s2.min_col;
        o_res.row_was_empty   = r_s2.was_empty;
        o_res.accepted        = w_acc;
        o_res.displaced_valid = w_acc && w_own_valid;
        o_res.displaced_row   = (w_acc && w_own_valid)
                                ? lsps_pkg::RowBits'(w_own_row) : '0;
        o_res.pivot_total     = n_count;
        o_res.column_error    = r_s2.err;
    end

    assign o_res_valid = r_s2_valid;
    assign o_busy      = r_clear;

    // Control: clearing pass, stage-two valid, forward register, pivot count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear    <= 1'b1;
            r_clr_addr <= '0;
            r_s2_valid <= 1'b0;
            r_fwd_en   <= 1'b0;
            r_count    <= '0;
        end else begin
            if (r_clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clear <= 1'b0;
                end
            end
            r_s2_valid <= i_end_valid;
            r_fwd_en   <= w_we;
            r_count    <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_end_valid) begin
            r_s2 <= i_end;
        end
        r_fwd_addr <= w_waddr;
        r_fwd_data <= w_wdata;
    end

endmodule

// File: hdl/lsps_out_buf.sv
// Two-entry result buffer between the table stage and the output channel.
module lsps_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lsps_pkg::t_result i_data,
    input  logic              i_ready,
    output logic              o_valid,
    output lsps_pkg::t_result o_data,
    output logic [1:0]        o_count
);

    lsps_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/lsps_checker.sv
// Port-level checker for the pivot search block, bound to the top level.
module lsps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [12:0] i_cfg_data
);

    logic w_out_hs;
    assign w_out_hs = o_m_axis_tvalid && i_m_axis_tready;

    // No result right after reset
    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Table sweep keeps the input closed right after reset
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready during table sweep");

    // A displaced owner only comes with an accepted pivot
    a_displace_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[29]) |-> o_m_axis_tdata[28])
        else $error("displaced row without accepted pivot");

    // An empty row never takes a pivot
    a_empty_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (!o_m_axis_tdata[28] && !o_m_axis_tdata[29] && o_m_axis_tdata[27:16] == 12'd0))
        else $error("empty row reported a pivot");

    // Pivot total grows by one for each new column between results handed over back to back
    a_pivot_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_hs && $past(w_out_hs) && $past(i_rst_n)) |->
            (o_m_axis_tdata[58:46] == $past(o_m_axis_tdata[58:46])
                + 13'(o_m_axis_tdata[28] && !o_m_axis_tdata[29])))
        else $error("pivot total out of step");

endmodule

bind leftmost_sparsest_pivot_search lsps_checker u_lsps_checker (.*);

// File: verif/tb_leftmost_sparsest_pivot_search.sv
// Self-checking testbench for the leftmost-sparsest pivot search block.
module tb_leftmost_sparsest_pivot_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxColumns   = 4096;
    localparam int RowIndexBits = 16;
    localparam int CycleLimit   = 60000;
    localparam int DrainSlack   = 8;
    localparam int ReportLimit  = 10;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stimulus side
    logic        entry_valid = 1'b0;
    logic [31:0] entry_data  = '0;
    logic        entry_empty = 1'b0;
    logic        entry_last  = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [12:0] cfg_data    = '0;
    logic        result_ready = 1'b0;

    // DUT outputs
    logic        entry_ready;
    logic        result_valid;
    logic [63:0] result_data;
    logic        result_empty;
    logic        cfg_ready;

    leftmost_sparsest_pivot_search #(
        .MAX_COLUMNS    (MaxColumns),
        .ROW_INDEX_BITS (RowIndexBits)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (entry_valid),
        .o_s_axis_tready (entry_ready),
        .i_s_axis_tdata  (entry_data),
        .i_s_axis_tuser  (entry_empty),
        .i_s_axis_tlast  (entry_last),
        .o_m_axis_tvalid (result_valid),
        .i_m_axis_tready (result_ready),
        .o_m_axis_tdata  (result_data),
        .o_m_axis_tuser  (result_empty),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // Pacing knobs, percent of cycles
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // Long hold-off request, served by the receiver process
    int hold_len    = 0;
    int hold_req_id = 0;
    int hold_ack_id = 0;
    int hold_left   = 0;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Predicted pivot table and per-row accumulator
    logic                            pivot_owned [MaxColumns];
    logic [lsps_pkg::RowBits-1:0]    pivot_owner_row [MaxColumns];
    logic [lsps_pkg::WeightBits-1:0] pivot_owner_weight [MaxColumns];
    logic [lsps_pkg::ColBits-1:0]    row_min_col  = lsps_pkg::MinReset;
    logic [lsps_pkg::WeightBits-1:0] row_weight   = '0;
    logic                            row_col_err  = 1'b0;
    logic [lsps_pkg::CountBits-1:0]  held_pivots  = '0;
    logic [lsps_pkg::NumColBits-1:0] num_columns_q = lsps_pkg::NumColReset;

    lsps_pkg::t_result expected_row_results[$];

    initial begin
        foreach (pivot_owned[c]) begin
            pivot_owned[c]        = 1'b0;
            pivot_owner_row[c]    = '0;
            pivot_owner_weight[c] = '0;
        end
    end

    // Update the predicted state with one accepted entry; queue a result at row end
    function automatic void predict_pivot_result(input logic [lsps_pkg::RowBits-1:0] row,
                                                 input logic [lsps_pkg::ColBits-1:0] col,
                                                 input logic empty, input logic last);
        logic [lsps_pkg::NumColBits-1:0] limit;
        lsps_pkg::t_result res;
        limit = (num_columns_q < lsps_pkg::NumColBits'(MaxColumns))
                ? num_columns_q : lsps_pkg::NumColBits'(MaxColumns);
        if (!empty) begin
            if ({1'b0, col} >= limit) begin
                row_col_err = 1'b1;
            end else begin
                if (row_weight == '0 || col < row_min_col) row_min_col = col;
                if (row_weight != lsps_pkg::WeightMax)
                    row_weight = row_weight + lsps_pkg::WeightBits'(1);
            end
            if (!last) return;
        end
        res = '0;
        res.done_row      = row;
        res.row_was_empty = 1'b1;
        res.column_error  = row_col_err;
        if (!empty && row_weight != '0) begin
            res.row_was_empty = 1'b0;
            res.pivot_column  = row_min_col;
            if (!pivot_owned[row_min_col]) begin
                res.accepted = 1'b1;
                held_pivots  = held_pivots + lsps_pkg::CountBits'(1);
            end else if (row_weight < pivot_owner_weight[row_min_col]) begin
                res.accepted        = 1'b1;
                res.displaced_valid = 1'b1;
                res.displaced_row   = pivot_owner_row[row_min_col];
            end
            if (res.accepted) begin
                pivot_owned[row_min_col]        = 1'b1;
                pivot_owner_row[row_min_col]    = row;
                pivot_owner_weight[row_min_col] = row_weight;
            end
        end
        res.pivot_total = held_pivots;
        row_min_col = lsps_pkg::MinReset;
        row_weight  = '0;
        row_col_err = 1'b0;
        expected_row_results.push_back(res);
    endfunction

    // Send one entry transaction, with random idle cycles ahead of it
    task automatic push_entry(input logic [lsps_pkg::RowBits-1:0] row,
                              input logic [lsps_pkg::ColBits-1:0] col,
                              input logic empty, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            entry_valid <= 1'b0;
            @(posedge i_clk);
        end
        entry_valid <= 1'b1;
        entry_data  <= {4'b0, col, row};
        entry_empty <= empty;
        entry_last  <= last;
        @(posedge i_clk);
        while (!entry_ready) @(posedge i_clk);
        predict_pivot_result(row, col, empty, last);
    endtask

    // Stop offering entries and wait until every predicted result came back
    task automatic wait_results_drained();
        entry_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_row_results.size() != 0) @(posedge i_clk);
        repeat (DrainSlack) @(posedge i_clk);
    endtask

    // Write num_columns while the block is idle
    task automatic write_num_columns(input logic [12:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        num_columns_q = value;
    endtask

    // Column choice: mostly a narrow hot window, sometimes full range or near the top
    function automatic logic [lsps_pkg::ColBits-1:0] pick_column(input int span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return lsps_pkg::ColBits'($urandom_range(span - 1));
        if (roll < 85) return lsps_pkg::ColBits'($urandom);
        return lsps_pkg::ColBits'(4095 - $urandom_range(15));
    endfunction

    // Field extremes, empty rows, displacement and the malformed row cases
    task automatic test_directed_rows();
        push_entry(16'h0000, 12'd0, 1'b0, 1'b1);
        push_entry(16'hFFFF, 12'd4095, 1'b0, 1'b1);
        // three entries, leftmost column 37
        push_entry(16'h5555, 12'd100, 1'b0, 1'b0);
        push_entry(16'h5555, 12'd37, 1'b0, 1'b0);
        push_entry(16'h5555, 12'd2000, 1'b0, 1'b1);
        // sparser row takes column 37 over
        push_entry(16'hAAAA, 12'd37, 1'b0, 1'b0);
        push_entry(16'hAAAA, 12'd3000, 1'b0, 1'b1);
        // same weight does not displace
        push_entry(16'h0007, 12'd38, 1'b0, 1'b0);
        push_entry(16'h0007, 12'd37, 1'b0, 1'b1);
        // empty rows, column ignored, with and without tlast
        push_entry(16'h1234, 12'hFFF, 1'b1, 1'b0);
        push_entry(16'h4321, 12'hABC, 1'b1, 1'b1);
        // empty mark discards pending entries
        push_entry(16'h0009, 12'd5, 1'b0, 1'b0);
        push_entry(16'h0009, 12'd0, 1'b1, 1'b0);
        // row index changes without end mark
        push_entry(16'h000A, 12'd50, 1'b0, 1'b0);
        push_entry(16'h000B, 12'd40, 1'b0, 1'b1);
        // repeated row index starts a new row
        push_entry(16'h0000, 12'd1, 1'b0, 1'b1);
        push_entry(16'h0000, 12'h800, 1'b0, 1'b1);
    endtask

    // Out-of-range columns under several num_columns settings
    task automatic test_column_limit();
        write_num_columns(13'd1);
        push_entry(16'h0100, 12'd1, 1'b0, 1'b1);
        push_entry(16'h0101, 12'd0, 1'b0, 1'b0);
        push_entry(16'h0101, 12'd4095, 1'b0, 1'b1);
        push_entry(16'h0102, 12'd0, 1'b0, 1'b1);
        write_num_columns(13'd0);
        push_entry(16'h0200, 12'd0, 1'b0, 1'b0);
        push_entry(16'h0200, 12'd3, 1'b0, 1'b1);
        push_entry(16'h0201, 12'd0, 1'b1, 1'b1);
        write_num_columns(13'h1FFF);
        push_entry(16'h0300, 12'd4095, 1'b0, 1'b0);
        push_entry(16'h0300, 12'd2047, 1'b0, 1'b1);
        write_num_columns(13'd4095);
        push_entry(16'h0400, 12'd4095, 1'b0, 1'b0);
        push_entry(16'h0400, 12'd4094, 1'b0, 1'b1);
        push_entry(16'h0401, 12'd4095, 1'b0, 1'b1);
        write_num_columns(13'd4096);
    endtask

    // Long rows on one column: equal weight keeps the owner, a sparser row displaces it
    task automatic test_long_rows();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 12; i++) push_entry(16'h2222, 12'd2222, 1'b0, i == 11);
        for (int i = 0; i < 12; i++) push_entry(16'h3333, 12'd2222, 1'b0, i == 11);
        for (int i = 0; i < 3; i++) push_entry(16'h4444, 12'd2222, 1'b0, i == 2);
        wait_results_drained();
    endtask

    // Mostly well-formed rows with random content, plus malformed rows
    task automatic test_random_rows(input int idle_pct, input int stall_pct,
                                    input logic [12:0] num_columns, input int span,
                                    input int item_budget);
        int sent;
        int kind;
        int len;
        logic [lsps_pkg::RowBits-1:0] row;
        write_num_columns(num_columns);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_budget) begin
            kind = $urandom_range(99);
            row  = lsps_pkg::RowBits'($urandom);
            len  = $urandom_range(1, 6);
            if (kind < 75) begin
                for (int i = 0; i < len; i++)
                    push_entry(row, pick_column(span), 1'b0, i == len - 1);
                sent += len;
            end else if (kind < 87) begin
                // empty mark, possibly after pending entries
                for (int i = 0; i < len - 1; i++)
                    push_entry(row, pick_column(span), 1'b0, 1'b0);
                push_entry(row, lsps_pkg::ColBits'($urandom), 1'b1, 1'($urandom_range(1)));
                sent += len;
            end else begin
                // row index changes before the end mark
                push_entry(row, lsps_pkg::ColBits'($urandom), 1'b0, 1'b0);
                push_entry(row ^ lsps_pkg::RowBits'($urandom), pick_column(span),
                           1'b0, 1'b1);
                sent += 2;
            end
        end
        wait_results_drained();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // Receiver holds off long enough that the block must stall its input
    task automatic test_output_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len    = 300;
        hold_req_id = hold_req_id + 1;
        for (int i = 0; i < 40; i++)
            push_entry(lsps_pkg::RowBits'($urandom),
                       lsps_pkg::ColBits'($urandom_range(31)), 1'b0, 1'b1);
        wait_results_drained();
    endtask

    // Receiver ready: random stalls, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req_id != hold_ack_id) begin
            hold_ack_id  <= hold_req_id;
            hold_left    <= hold_len;
            result_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end else begin
            result_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        lsps_pkg::t_result got;
        lsps_pkg::t_result want;
        string             bad;
        if (i_rst_n && result_valid && result_ready) begin
            got = '0;
            got.done_row        = result_data[15:0];
            got.pivot_column    = result_data[27:16];
            got.accepted        = result_data[28];
            got.displaced_valid = result_data[29];
            got.displaced_row   = result_data[45:30];
            got.pivot_total     = result_data[58:46];
            got.column_error    = result_data[59];
            got.row_was_empty   = result_empty;
            if (expected_row_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit)
                    $display("unexpected result transaction: %h", got);
            end else begin
                want = expected_row_results.pop_front();
                bad  = "";
                if (got.done_row !== want.done_row) bad = {bad, " done_row"};
                if (got.pivot_column !== want.pivot_column) bad = {bad, " pivot_column"};
                if (got.row_was_empty !== want.row_was_empty) bad = {bad, " row_was_empty"};
                if (got.accepted !== want.accepted) bad = {bad, " accepted"};
                if (got.displaced_valid !== want.displaced_valid)
                    bad = {bad, " displaced_valid"};
                if (got.displaced_row !== want.displaced_row) bad = {bad, " displaced_row"};
                if (got.pivot_total !== want.pivot_total) bad = {bad, " pivot_total"};
                if (got.column_error !== want.column_error) bad = {bad, " column_error"};
                if (bad != "") begin
                    mismatch_count++;
                    if (mismatch_count <= ReportLimit)
                        $display("row %h mismatch in%s: expected %h, got %h",
                                 want.done_row, bad, want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("[leftmost_sparsest_pivot_search] ERROR");
            $finish;
        end
    end

    // Test sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_rows();
        test_column_limit();
        test_long_rows();
        test_random_rows(0, 0, 13'd4096, 24, 80);
        test_random_rows(55, 0, 13'd300, 40, 80);
        test_random_rows(0, 55, 13'd16, 16, 80);
        test_random_rows(24, 24, 13'd4096, 64, 80);
        test_output_backpressure();
        wait_results_drained();
        if (mismatch_count == 0) begin
            $display("[leftmost_sparsest_pivot_search] OK");
        end else begin
            $display("[leftmost_sparsest_pivot_search] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/lsps_pkg.sv
hdl/lsps_ram.sv
hdl/lsps_row_acc.sv
hdl/lsps_pivot_table.sv
hdl/lsps_out_buf.sv
hdl/leftmost_sparsest_pivot_search.sv
hdl/lsps_checker.sv
verif/tb_leftmost_sparsest_pivot_search.sv
